// ----- hw/rtl/mr_pkg.sv -----
// ---------------------------------------------------------------------------
// Miller-Rabin package
// Shared constants and types, among them the class of the item passed from front end to back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mr_pkg;

  localparam int unsigned NumWidthDefault = 64;
  localparam int unsigned FifoDepth       = 2;

  // Class of an item as decided by the front end.
  typedef enum logic [1:0] {
    ClsPrime,
    ClsComposite,
    ClsBadWitness,
    ClsTest
  } cls_e;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    StIdle,
    StPow,
    StSquare,
    StMul,
    StDone
  } be_state_e;

endpackage

// ----- hw/rtl/mr_front.sv -----
// ---------------------------------------------------------------------------
// Miller-Rabin front end
// Masks the operands, classifies each item and writes it to a short queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mr_front #(
  parameter int unsigned NumWidth = mr_pkg::NumWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [63:0]         candidate_i,
  input  logic [63:0]         witness_i,
  input  logic                last_round_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output mr_pkg::cls_e        q_cls_o,
  output logic [NumWidth-1:0] q_n_o,
  output logic [NumWidth-1:0] q_w_o,
  output logic                q_last_o
);

  localparam int unsigned PtrW = $clog2(mr_pkg::FifoDepth);

  logic [NumWidth-1:0] n, w;
  mr_pkg::cls_e        cls;

  assign n = candidate_i[NumWidth-1:0];
  assign w = witness_i[NumWidth-1:0];

  // Classify the candidate and check the witness range.
  always_comb begin
    if (n == NumWidth'(2) || n == NumWidth'(3)) begin
      cls = mr_pkg::ClsPrime;
    end else if (n < NumWidth'(2) || !n[0]) begin
      cls = mr_pkg::ClsComposite;
    end else if (w < NumWidth'(2) || w > n - NumWidth'(2)) begin
      cls = mr_pkg::ClsBadWitness;
    end else begin
      cls = mr_pkg::ClsTest;
    end
  end

  // Small queue of classified items.
  mr_pkg::cls_e        cls_q  [mr_pkg::FifoDepth];
  logic [NumWidth-1:0] n_q    [mr_pkg::FifoDepth];
  logic [NumWidth-1:0] w_q    [mr_pkg::FifoDepth];
  logic                last_q [mr_pkg::FifoDepth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]       cnt_q, cnt_d;
  logic                push, pop;

  assign ready_o   = cnt_q != (PtrW+1)'(mr_pkg::FifoDepth);
  assign q_valid_o = cnt_q != '0;
  assign push      = valid_i && ready_o;
  assign pop       = q_valid_o && q_ready_i;
  assign q_cls_o   = cls_q[rd_q];
  assign q_n_o     = n_q[rd_q];
  assign q_w_o     = w_q[rd_q];
  assign q_last_o  = last_q[rd_q];

  always_comb begin
    wr_d  = push ? PtrW'(wr_q + 1'b1) : wr_q;
    rd_d  = pop ? PtrW'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cls_q[wr_q]  <= cls;
      n_q[wr_q]    <= n;
      w_q[wr_q]    <= w;
      last_q[wr_q] <= last_round_i;
    end
  end

endmodule

// ----- hw/rtl/mr_mulmod.sv -----
// ---------------------------------------------------------------------------
// Miller-Rabin modular multiplier
// Bit-serial shift-and-add (a * b) mod m, one bit of b per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mr_mulmod #(
  parameter int unsigned NumWidth = mr_pkg::NumWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NumWidth-1:0] a_i,
  input  logic [NumWidth-1:0] b_i,
  input  logic [NumWidth-1:0] m_i,
  output logic                done_o,
  output logic [NumWidth-1:0] p_o
);

  localparam int unsigned CntW = $clog2(NumWidth + 1);

  logic [NumWidth-1:0] acc_q, acc_d, a_q, a_d, b_q, b_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                fin_q;
  logic [NumWidth:0]   dbl, dbl_r, add, add_r;

  // Double then conditionally add, each reduced by one subtract.
  always_comb begin
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, m_i}) ? dbl - {1'b0, m_i} : dbl;
    add   = dbl_r + {1'b0, a_q};
    add_r = (add >= {1'b0, m_i}) ? add - {1'b0, m_i} : add;
    acc_d = acc_q;
    a_d   = a_q;
    b_d   = b_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      acc_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      cnt_d  = CntW'(NumWidth);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = b_q[NumWidth-1] ? add_r[NumWidth-1:0] : dbl_r[NumWidth-1:0];
      b_d   = {b_q[NumWidth-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  assign p_o    = acc_q;
  assign done_o = fin_q;

  // Done is flagged in the cycle after the last bit, while busy is clear.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      fin_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      fin_q  <= busy_q && cnt_q == CntW'(1) && !start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

endmodule

// ----- hw/rtl/mr_back.sv -----
// ---------------------------------------------------------------------------
// Miller-Rabin back end
// Runs the modular exponentiation and squarings and holds the result item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mr_back #(
  parameter int unsigned NumWidth = mr_pkg::NumWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  mr_pkg::cls_e        q_cls_i,
  input  logic [NumWidth-1:0] q_n_i,
  input  logic [NumWidth-1:0] q_w_i,
  input  logic                q_last_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic                probably_prime_o,
  output logic                bad_witness_o,
  output logic                final_round_o
);

  localparam int unsigned SW = $clog2(NumWidth + 1);

  mr_pkg::be_state_e st_q, st_d, ret_q, ret_d;
  logic [NumWidth-1:0] n_q, n_d, e_q, e_d, acc_q, acc_d, sq_q, sq_d, x_q, x_d;
  logic [SW-1:0]       s_q, s_d;
  logic                last_q, last_d, all_q, all_d, ov_q, ov_d;
  logic                pp_q, pp_d, bad_q, bad_d, fin_q, fin_d;
  logic                step_q, step_d;

  logic                mstart, mdone;
  logic [NumWidth-1:0] ma, mb, mp;

  // Shared bit-serial multiplier.
  mr_mulmod #(.NumWidth(NumWidth)) u_mul (
    .clk_i, .rst_ni, .start_i(mstart), .a_i(ma), .b_i(mb), .m_i(n_q),
    .done_o(mdone), .p_o(mp)
  );

  logic [NumWidth-1:0] nm1;
  logic                pass_v, fail_v, can_out;
  assign nm1 = n_q - NumWidth'(1);
  assign can_out = !ov_q || ready_i;

  // Sequencer: decompose n-1, power, then squarings.
  always_comb begin
    st_d = st_q; ret_d = ret_q; n_d = n_q; e_d = e_q; acc_d = acc_q;
    sq_d = sq_q; x_d = x_q; s_d = s_q; last_d = last_q; all_d = all_q;
    ov_d = ov_q && !ready_i; pp_d = pp_q; bad_d = bad_q; fin_d = fin_q;
    step_d = step_q; mstart = 1'b0; ma = acc_q; mb = sq_q;
    q_ready_o = 1'b0; pass_v = 1'b0; fail_v = 1'b0;
    case (st_q)
      mr_pkg::StIdle: begin
        q_ready_o = can_out;
        if (q_valid_i && can_out) begin
          n_d = q_n_i; last_d = q_last_i; bad_d = 1'b0;
          case (q_cls_i)
            mr_pkg::ClsPrime: pass_v = 1'b1;
            mr_pkg::ClsComposite: fail_v = 1'b1;
            mr_pkg::ClsBadWitness: begin
              fail_v = 1'b1; bad_d = 1'b1;
            end
            default: begin
              e_d = q_n_i - NumWidth'(1); s_d = '0; sq_d = q_w_i;
              acc_d = NumWidth'(1); st_d = mr_pkg::StDone;
            end
          endcase
        end
      end
      // StDone here strips trailing zeros of n-1, one bit a cycle.
      mr_pkg::StDone: begin
        if (!e_q[0]) begin
          e_d = e_q >> 1; s_d = s_q + 1'b1;
        end else begin
          st_d = mr_pkg::StPow; step_d = 1'b0;
        end
      end
      mr_pkg::StPow: begin
        if (e_q == '0) begin
          x_d = acc_q;
          st_d = mr_pkg::StSquare;
          step_d = 1'b0;
        end else begin
          ma = step_q ? sq_q : acc_q; mb = sq_q;
          mstart = 1'b1; ret_d = mr_pkg::StPow; st_d = mr_pkg::StMul;
        end
      end
      mr_pkg::StMul: begin
        ma = acc_q; mb = sq_q;
        if (mdone) begin
          st_d = ret_q;
          if (ret_q == mr_pkg::StPow) begin
            if (!step_q) begin
              if (e_q[0]) acc_d = mp;
              step_d = 1'b1;
            end else begin
              sq_d = mp; e_d = e_q >> 1; step_d = 1'b0;
            end
          end else begin
            x_d = mp; s_d = s_q - 1'b1; step_d = 1'b1;
          end
        end
      end
      mr_pkg::StSquare: begin
        // First visit checks x itself; later visits check a fresh square.
        if (!step_q) begin
          if (x_q == NumWidth'(1) || x_q == nm1) begin
            pass_v = 1'b1;
          end else if (s_q <= SW'(1)) begin
            fail_v = 1'b1;
          end else begin
            ma = x_q; mb = x_q; mstart = 1'b1;
            ret_d = mr_pkg::StSquare; st_d = mr_pkg::StMul;
          end
        end else begin
          if (x_q == NumWidth'(1)) begin
            fail_v = 1'b1;
          end else if (x_q == nm1) begin
            pass_v = 1'b1;
          end else if (s_q <= SW'(1)) begin
            fail_v = 1'b1;
          end else begin
            ma = x_q; mb = x_q; mstart = 1'b1;
            ret_d = mr_pkg::StSquare; st_d = mr_pkg::StMul;
          end
        end
        if ((pass_v || fail_v) && !can_out) begin
          pass_v = 1'b0; fail_v = 1'b0; mstart = 1'b0;
          st_d = mr_pkg::StSquare;
        end
      end
      default: st_d = mr_pkg::StIdle;
    endcase
    // Result forms only in idle (immediate) or after a square check.
    if (pass_v || fail_v) begin
      pp_d  = all_q && pass_v;
      all_d = last_d ? 1'b1 : (all_q && pass_v);
      fin_d = last_d;
      ov_d  = 1'b1;
      st_d  = mr_pkg::StIdle;
    end
  end

  assign valid_o          = ov_q;
  assign probably_prime_o = pp_q;
  assign bad_witness_o    = bad_q && ov_q;
  assign final_round_o    = fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= mr_pkg::StIdle;
      ret_q <= mr_pkg::StPow;
      all_q <= 1'b1;
      ov_q  <= 1'b0;
      step_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      ret_q <= ret_d;
      all_q <= all_d;
      ov_q  <= ov_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; e_q <= e_d; acc_q <= acc_d; sq_q <= sq_d; x_q <= x_d;
    s_q <= s_d; last_q <= last_d; pp_q <= pp_d; bad_q <= bad_d; fin_q <= fin_d;
  end

endmodule

// ----- hw/rtl/miller_rabin_prime_test.sv -----
// ---------------------------------------------------------------------------
// Miller-Rabin prime test
// One witness round per item, rounds ANDed until the item marked last.
// ---------------------------------------------------------------------------
//  Channel | Handshake             | Payload
//  input   | valid_i / ready_o     | candidate_i, witness_i, last_round_i
//  output  | valid_o / ready_i     | probably_prime_o, bad_witness_o, final_round_o
//
// A trivial item is decided in idle and needs no product. The time of a full
// round is set by the bit-serial modular multiplier shared by every product.
// Reset clears the queue, the sequencer and sets the running flag to one.
// A two-entry queue parts the front end from the back end.
`timescale 1ns / 1ps

module miller_rabin_prime_test #(
  parameter int unsigned NumWidth = mr_pkg::NumWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [63:0] candidate_i,
  input  logic [63:0] witness_i,
  input  logic        last_round_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic        probably_prime_o,
  output logic        bad_witness_o,
  output logic        final_round_o
);

  logic                qv, qr, ql;
  mr_pkg::cls_e        qc;
  logic [NumWidth-1:0] qn, qw;

  mr_front #(.NumWidth(NumWidth)) u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .candidate_i, .witness_i, .last_round_i,
    .q_valid_o(qv), .q_ready_i(qr), .q_cls_o(qc), .q_n_o(qn), .q_w_o(qw),
    .q_last_o(ql)
  );

  mr_back #(.NumWidth(NumWidth)) u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .q_ready_o(qr), .q_cls_i(qc), .q_n_i(qn),
    .q_w_i(qw), .q_last_i(ql), .valid_o, .ready_i, .probably_prime_o,
    .bad_witness_o, .final_round_o
  );

endmodule

// ----- dv/mr_verdict_checker.sv -----
// ---------------------------------------------------------------------------
// Miller-Rabin verdict checker
// Watches both channels, computes the expected verdict of every accepted
// item and compares each result item, field by field, in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mr_verdict_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        ready_o,
  input  logic [63:0] candidate_i,
  input  logic [63:0] witness_i,
  input  logic        last_round_i,
  input  logic        valid_o,
  input  logic        ready_i,
  input  logic        probably_prime_o,
  input  logic        bad_witness_o,
  input  logic        final_round_o,
  output int          fail_cnt_o,
  output int          pending_o
);

  typedef struct packed {
    logic probably_prime;
    logic bad_witness;
    logic final_round;
  } verdict_t;

  verdict_t   verdict_q[$];
  logic       all_rounds_ok;
  int         fail_cnt;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = verdict_q.size();

  // Products are formed at 128 bits so that any 64-bit modulus is exact.
  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return 64'(prod % {64'd0, m});
  endfunction

  function automatic logic [63:0] powmod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    acc = 64'd1;
    sq  = b;
    while (e != 64'd0) begin
      if (e[0]) acc = mulmod(acc, sq, m);
      sq = mulmod(sq, sq, m);
      e  = e >> 1;
    end
    return acc;
  endfunction

  // One strong-probable-prime round for odd n above 3 and witness in range.
  function automatic logic witness_round_passes(logic [63:0] n, logic [63:0] w);
    logic [63:0] t;
    int          s;
    logic [63:0] x;
    t = n - 64'd1;
    s = 0;
    while (!t[0]) begin
      t = t >> 1;
      s++;
    end
    x = powmod(w, t, n);
    if (x == 64'd1 || x == n - 64'd1) return 1'b1;
    for (int j = 1; j < s; j++) begin
      x = mulmod(x, x, n);
      if (x == 64'd1) return 1'b0;
      if (x == n - 64'd1) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Predict on input acceptance and compare on output acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    logic     pass;
    logic     bad;
    verdict_t exp_v;
    if (!rst_ni) begin
      all_rounds_ok = 1'b1;
      fail_cnt      = 0;
      verdict_q.delete();
    end else begin
      if (valid_i && ready_o) begin
        bad = 1'b0;
        if (candidate_i == 64'd2 || candidate_i == 64'd3) begin
          pass = 1'b1;
        end else if (candidate_i < 64'd2 || !candidate_i[0]) begin
          pass = 1'b0;
        end else if (witness_i < 64'd2 || witness_i > candidate_i - 64'd2) begin
          bad  = 1'b1;
          pass = 1'b0;
        end else begin
          pass = witness_round_passes(candidate_i, witness_i);
        end
        exp_v.probably_prime = all_rounds_ok & pass;
        exp_v.bad_witness    = bad;
        exp_v.final_round    = last_round_i;
        all_rounds_ok = last_round_i ? 1'b1 : exp_v.probably_prime;
        verdict_q.insert(verdict_q.size(), exp_v);
      end
      if (valid_o && ready_i) begin
        if (verdict_q.size() == 0) begin
          $error("result item with no expectation waiting");
          fail_cnt++;
        end else begin
          exp_v = verdict_q.pop_front();
          if (probably_prime_o !== exp_v.probably_prime) begin
            $error("probably_prime: expected %0d, actual %0d",
                   exp_v.probably_prime, probably_prime_o);
            fail_cnt++;
          end
          if (bad_witness_o !== exp_v.bad_witness) begin
            $error("bad_witness: expected %0d, actual %0d",
                   exp_v.bad_witness, bad_witness_o);
            fail_cnt++;
          end
          if (final_round_o !== exp_v.final_round) begin
            $error("final_round: expected %0d, actual %0d",
                   exp_v.final_round, final_round_o);
            fail_cnt++;
          end
        end
      end
    end
  end

endmodule

// ----- dv/miller_rabin_prime_test_tb.sv -----
// ---------------------------------------------------------------------------
// Miller-Rabin prime test testbench
// Directed edge cases, then random witness sequences on known primes,
// pseudoprimes and random odd numbers, with random gaps on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module miller_rabin_prime_test_tb;

  localparam int unsigned IdleLimit = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        ready_o;
  logic [63:0] candidate_i;
  logic [63:0] witness_i;
  logic        last_round_i;
  logic        valid_o;
  logic        ready_i;
  logic        probably_prime_o;
  logic        bad_witness_o;
  logic        final_round_o;
  int          fail_cnt;
  int          pending;
  int          sent_cnt;
  int          idle_cycles;
  logic        big_hold_req;

  logic [63:0] known_nums[14] = '{
    64'd5, 64'd7, 64'd13, 64'd97, 64'd65537, 64'd1000000007, 64'd4294967291,
    64'hFFFF_FFFF_FFFF_FFC5, 64'd561, 64'd1105, 64'd9, 64'd25326001,
    64'd3215031751, 64'd341
  };

  miller_rabin_prime_test uut (.*);

  mr_verdict_checker u_checker (
    .clk_i, .rst_ni, .valid_i, .ready_o, .candidate_i, .witness_i, .last_round_i,
    .valid_o, .ready_i, .probably_prime_o, .bad_witness_o, .final_round_o,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Offer one item after a random gap and hold it until it is accepted.
  task automatic send_item(logic [63:0] n, logic [63:0] w, logic last);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    gap  = (pick < 70) ? 0 : (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 100);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i      <= 1'b1;
    candidate_i  <= n;
    witness_i    <= w;
    last_round_i <= last;
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
    sent_cnt++;
  endtask

  // A witness drawn uniformly enough from 2..n-2, n odd and at least 5.
  function automatic logic [63:0] good_witness(logic [63:0] n);
    return (rand64() % (n - 64'd3)) + 64'd2;
  endfunction

  // Receiver: random stalls, mostly short, and a long hold-off on each request.
  initial begin
    int run_cnt;
    int stall_cnt;
    int pick;
    ready_i   <= 1'b0;
    run_cnt   = 0;
    stall_cnt = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (big_hold_req) begin
        big_hold_req = 1'b0;
        ready_i <= 1'b0;
        repeat (30000) @(posedge clk_i);
      end
      if (stall_cnt > 0) begin
        ready_i <= 1'b0;
        stall_cnt--;
      end else if (run_cnt > 0) begin
        ready_i <= 1'b1;
        run_cnt--;
      end else begin
        pick      = $urandom_range(0, 99);
        run_cnt   = (pick < 15) ? $urandom_range(100, 300) : $urandom_range(0, 20);
        pick      = $urandom_range(0, 99);
        stall_cnt = (pick < 90) ? $urandom_range(0, 3) : $urandom_range(20, 200);
        ready_i <= (stall_cnt == 0);
      end
    end
  end

  // Watchdog on cycles with no item accepted on either side.
  always @(posedge clk_i) begin
    if ((valid_i && ready_o) || (valid_o && ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [63:0] n;
    int          rounds;
    int          pick;
    int          end_wait;
    rst_ni       = 1'b0;
    valid_i      <= 1'b0;
    candidate_i  <= '0;
    witness_i    <= '0;
    last_round_i <= 1'b0;
    sent_cnt     = 0;
    idle_cycles  = 0;
    big_hold_req = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed: small primes, trivial composites, witness range edges.
    send_item(64'd2, 64'd0, 1'b1);
    send_item(64'd3, '1, 1'b1);
    send_item(64'd0, 64'd5, 1'b0);
    send_item(64'd1, '1, 1'b1);
    send_item(64'd4, 64'd2, 1'b1);
    send_item('1 - 64'd1, 64'd3, 1'b1);
    send_item(64'd5, 64'd0, 1'b1);
    send_item(64'd5, 64'd1, 1'b1);
    send_item(64'd5, 64'd4, 1'b1);
    send_item(64'd5, 64'd2, 1'b0);
    send_item(64'd5, 64'd3, 1'b1);
    send_item(64'd97, 64'd95, 1'b1);
    send_item(64'd97, 64'd96, 1'b0);
    send_item(64'd97, 64'd2, 1'b1);
    send_item(64'd561, 64'd2, 1'b0);
    send_item(64'd561, 64'd5, 1'b1);
    send_item(64'd2047, 64'd2, 1'b1);
    send_item('1, '1, 1'b1);
    send_item('1, 64'd2, 1'b1);
    send_item(64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFC3, 1'b0);
    send_item(64'hFFFF_FFFF_FFFF_FFC5, 64'h8000_0000_0000_0001, 1'b1);
    send_item(64'd9, 64'd2, 1'b0);
    send_item(64'd3, 64'd0, 1'b1);

    // Random: mostly well-formed round sequences, the rest noise.
    while (sent_cnt < 100) begin
      if (sent_cnt >= 45 && sent_cnt < 50) big_hold_req = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) n = known_nums[$urandom_range(0, 13)];
        else if (pick < 90) n = {48'd0, 16'($urandom())} | 64'd5;
        else n = rand64() | 64'd1;
        rounds = $urandom_range(1, 4);
        for (int r = 0; r < rounds; r++)
          send_item(n, good_witness(n), r == rounds - 1);
      end else begin
        pick = $urandom_range(0, 4);
        case (pick)
          0: send_item(rand64() & ~64'd1, rand64(), 1'($urandom()));
          1: send_item(64'($urandom_range(0, 3)), rand64(), 1'($urandom()));
          2: send_item(rand64() | 64'd1, rand64() | (64'd1 << 63), 1'($urandom()));
          3: send_item(64'd101, 64'($urandom_range(0, 1)), 1'($urandom()));
          default: send_item(64'd101, 64'($urandom_range(99, 100)), 1'($urandom()));
        endcase
      end
    end
    valid_i <= 1'b0;

    // Drain outstanding results, then allow a short tail for stray items.
    while (pending != 0) @(posedge clk_i);
    end_wait = 0;
    while (end_wait < 200) begin
      @(posedge clk_i);
      end_wait++;
    end
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/mr_pkg.sv
hw/rtl/mr_front.sv
hw/rtl/mr_mulmod.sv
hw/rtl/mr_back.sv
hw/rtl/miller_rabin_prime_test.sv
dv/mr_verdict_checker.sv
dv/miller_rabin_prime_test_tb.sv
